### hw/rtl/rgb_to_yuv420_semiplanar_assert.svh
// assertion macros shared by the checker
`ifndef RGB_TO_YUV420_SEMIPLANAR_ASSERT_SVH
`define RGB_TO_YUV420_SEMIPLANAR_ASSERT_SVH

// checked on every rising edge outside reset
`define RYUV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every rising edge, reset included
`define RYUV_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hw/rtl/ryuv420_pkg.sv
package ryuv420_pkg;

  localparam int PIXEL_W   = 32;
  localparam int BYTE_W    = 8;
  localparam int LUMA_AW   = 24;
  localparam int CHROMA_AW = 25;
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 2;
  localparam int M_TDATA_W = 80;
  localparam int M_PAD_W   = M_TDATA_W - (3 * BYTE_W + LUMA_AW + CHROMA_AW);

  // register map
  localparam logic [CFG_IDX_W-1:0] REG_INPUT_FORMAT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHROMA_ORDER = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd3;

  localparam logic FMT_RGBA8888 = 1'b0;
  localparam logic FMT_RGB565   = 1'b1;
  localparam logic ORDER_NV12   = 1'b0;
  localparam logic ORDER_NV21   = 1'b1;

  localparam logic [CFG_W-1:0] WIDTH_RESET  = 13'd640;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 13'd480;

  // bt.601 matrix, 12 fractional bits
  localparam int ACC_W = 22;
  typedef logic signed [ACC_W-1:0] acc_t;

  localparam acc_t K_YR = 22'sd1225;
  localparam acc_t K_YG = 22'sd2404;
  localparam acc_t K_YB = 22'sd467;
  localparam acc_t K_CR_G = 22'sd1715;
  localparam acc_t K_CR_B = 22'sd333;
  localparam acc_t K_CB_R = 22'sd691;
  localparam acc_t K_CB_G = 22'sd1357;
  localparam acc_t K_UNIT = 22'sd2048;
  localparam acc_t CHROMA_BIAS = 22'sd524288;
  localparam int FRAC_W = 12;

  typedef struct packed {
    logic accept;  // input transaction, loads the input stage
    logic ld1;     // middle stage advances
    logic ld2;     // output register advances
  } pipe_ctrl_t;

endpackage

### hw/rtl/ryuv420_color.sv
module ryuv420_color (
  input  logic                             clk,
  input  ryuv420_pkg::pipe_ctrl_t          ctrl,
  input  logic                             input_format,
  input  logic                             chroma_order,
  input  logic [ryuv420_pkg::PIXEL_W-1:0]  pixel,
  output logic [ryuv420_pkg::BYTE_W-1:0]   luma,
  output logic [ryuv420_pkg::BYTE_W-1:0]   chroma_first,
  output logic [ryuv420_pkg::BYTE_W-1:0]   chroma_second
);
  import ryuv420_pkg::*;

  function automatic acc_t ext(input logic [BYTE_W-1:0] v);
    return acc_t'({{(ACC_W-BYTE_W){1'b0}}, v});
  endfunction

  // shift down and saturate to 0..255
  function automatic logic [BYTE_W-1:0] to_byte(input acc_t a);
    logic [BYTE_W-1:0] res;
    if (a[ACC_W-1]) begin
      res = '0;
    end else if (|a[ACC_W-2:FRAC_W+BYTE_W]) begin
      res = '1;
    end else begin
      res = a[FRAC_W+BYTE_W-1:FRAC_W];
    end
    return res;
  endfunction

  logic [BYTE_W-1:0] r_in, g_in, b_in;
  logic [BYTE_W-1:0] r0, g0, b0;
  acc_t y_acc, cb_acc, cr_acc;

  // 565 channels widened by bit replication
  always_comb begin
    if (input_format == FMT_RGB565) begin
      r_in = {pixel[15:11], pixel[15:13]};
      g_in = {pixel[10:5], pixel[10:9]};
      b_in = {pixel[4:0], pixel[4:2]};
    end else begin
      r_in = pixel[7:0];
      g_in = pixel[15:8];
      b_in = pixel[23:16];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      r0 <= r_in;
      g0 <= g_in;
      b0 <= b_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.ld1) begin
      y_acc  <= K_YR * ext(r0) + K_YG * ext(g0) + K_YB * ext(b0);
      cr_acc <= CHROMA_BIAS + K_UNIT * ext(r0) - K_CR_G * ext(g0) - K_CR_B * ext(b0);
      cb_acc <= CHROMA_BIAS - K_CB_R * ext(r0) - K_CB_G * ext(g0) + K_UNIT * ext(b0);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.ld2) begin
      luma <= to_byte(y_acc);
      if (chroma_order == ORDER_NV21) begin
        chroma_first  <= to_byte(cr_acc);
        chroma_second <= to_byte(cb_acc);
      end else begin
        chroma_first  <= to_byte(cb_acc);
        chroma_second <= to_byte(cr_acc);
      end
    end
  end

endmodule

### hw/rtl/ryuv420_addr.sv
module ryuv420_addr #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                               clk,
  input  logic                               rst,
  input  ryuv420_pkg::pipe_ctrl_t            ctrl,
  input  logic [ryuv420_pkg::CFG_W-1:0]      image_width,
  input  logic [ryuv420_pkg::CFG_W-1:0]      image_height,
  output logic [ryuv420_pkg::LUMA_AW-1:0]    luma_addr,
  output logic [ryuv420_pkg::CHROMA_AW-1:0]  chroma_addr,
  output logic                               chroma_valid,
  output logic                               frame_end
);
  import ryuv420_pkg::*;

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int SUM_W = (WW + HW + 2 > CHROMA_AW + 1) ? WW + HW + 2 : CHROMA_AW + 1;

  logic [WW-1:0] w;
  logic [HW-1:0] h;
  logic [CW-1:0] column_count, column_count_next;
  logic [RW-1:0] row_count, row_count_next;
  logic          col_wrap, row_wrap;

  logic [CW-1:0] col0, col1;
  logic [RW-1:0] row0;
  logic          cv0, fe0, cv1, fe1;
  logic [RW+WW-1:0] prod_lu, prod_ch;
  logic [WW+HW-1:0] prod_wh;
  logic [SUM_W-1:0] luma_sum, chroma_sum;

  // effective frame size
  always_comb begin
    if (image_width == '0) begin
      w = WW'(1);
    end else if (32'(image_width) > 32'(MAX_WIDTH)) begin
      w = WW'(MAX_WIDTH);
    end else begin
      w = WW'(image_width);
    end
    if (image_height == '0) begin
      h = HW'(1);
    end else if (32'(image_height) > 32'(MAX_HEIGHT)) begin
      h = HW'(MAX_HEIGHT);
    end else begin
      h = HW'(image_height);
    end
  end

  always_comb begin
    col_wrap = (32'(column_count) + 32'd1) >= 32'(w);
    row_wrap = (32'(row_count) + 32'd1) >= 32'(h);
    column_count_next = column_count + CW'(1);
    row_count_next    = row_count;
    if (col_wrap) begin
      column_count_next = '0;
      row_count_next    = row_wrap ? '0 : row_count + RW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (ctrl.accept) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.accept) begin
      col0 <= column_count;
      row0 <= row_count;
      cv0  <= ~column_count[0];
      fe0  <= col_wrap & row_wrap;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.ld1) begin
      prod_lu <= (RW+WW)'(row0) * (RW+WW)'(w);
      prod_ch <= (RW+WW)'(row0 >> 1) * (RW+WW)'(w);
      prod_wh <= (WW+HW)'(w) * (WW+HW)'(h);
      col1    <= col0;
      cv1     <= cv0;
      fe1     <= fe0;
    end
  end

  assign luma_sum   = SUM_W'(prod_lu) + SUM_W'(col1);
  assign chroma_sum = SUM_W'(prod_wh) + SUM_W'(prod_ch) + SUM_W'(col1);

  always_ff @(posedge clk) begin
    if (ctrl.ld2) begin
      luma_addr    <= luma_sum[LUMA_AW-1:0];
      chroma_addr  <= cv1 ? chroma_sum[CHROMA_AW-1:0] : '0;
      chroma_valid <= cv1;
      frame_end    <= fe1;
    end
  end

endmodule

### hw/rtl/rgb_to_yuv420_semiplanar.sv
// rgb pixel stream to nv12 / nv21 semiplanar writes, bt.601 integer matrix
//
// s_* takes one pixel per transaction in raster order: rgba8888 (r in the low
// byte, alpha ignored) or rgb565 in the low half word, chosen by input_format.
// m_* gives one result per pixel: the luma byte and its plane offset, and on
// even columns the chroma pair with its offset in the chroma plane (chroma
// bytes and offset read zero on odd columns). tlast marks the last pixel of
// the frame. odd rows rewrite the chroma offsets of the even row above.
// cfg_wr_en / cfg_index / cfg_data write the four registers; change them only
// while no pixel is in flight, the position counters are never touched.
// the result moves through the input register, the middle stage and the output register.
// throughput: one pixel per clock while m_tready holds high, the three register
// stages each take one per cycle.
// reset: counters back to row 0 column 0, registers to 8888 / nv12 / 640x480,
// the pipeline empties. a stalled receiver holds the output register; the
// two stages in front keep filling, then s_tready drops until m_tready rises.
module rgb_to_yuv420_semiplanar #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // pixel input, tdata: pixel[31:0]
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [ryuv420_pkg::PIXEL_W-1:0]      s_tdata,
  // result, tdata: luma[7:0], luma_addr[31:8], chroma_first[39:32],
  // chroma_second[47:40], chroma_addr[72:48], zero pad[79:73]
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [ryuv420_pkg::M_TDATA_W-1:0]    m_tdata,
  output logic                                 m_tuser,  // chroma_valid
  output logic                                 m_tlast,  // frame_end
  // register writes
  input  logic                                 cfg_wr_en,
  input  logic [ryuv420_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ryuv420_pkg::CFG_W-1:0]        cfg_data
);
  import ryuv420_pkg::*;

  logic             input_format;
  logic             chroma_order;
  logic [CFG_W-1:0] image_width;
  logic [CFG_W-1:0] image_height;

  // stage valids: input register, middle stage, output register (m_tvalid)
  logic       v0, v1;
  logic       adv0, adv1, adv2;
  pipe_ctrl_t ctrl;

  logic [BYTE_W-1:0]    luma, chroma_first, chroma_second;
  logic [BYTE_W-1:0]    chroma_mask;
  logic [LUMA_AW-1:0]   luma_addr;
  logic [CHROMA_AW-1:0] chroma_addr;
  logic                 chroma_valid, frame_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      input_format <= FMT_RGBA8888;
      chroma_order <= ORDER_NV12;
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_INPUT_FORMAT: input_format <= cfg_data[0];
        REG_CHROMA_ORDER: chroma_order <= cfg_data[0];
        REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // a stage moves when it is empty or the stage after it moves
  assign adv2 = ~m_tvalid | m_tready;
  assign adv1 = ~v1 | adv2;
  assign adv0 = ~v0 | adv1;
  assign s_tready = adv0;

  assign ctrl.accept = s_tvalid & adv0;
  assign ctrl.ld1    = adv1;
  assign ctrl.ld2    = adv2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0       <= 1'b0;
      v1       <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (adv0) v0 <= s_tvalid;
      if (adv1) v1 <= v0;
      if (adv2) m_tvalid <= v1;
    end
  end

  ryuv420_color u_color (
    .clk           (clk),
    .ctrl          (ctrl),
    .input_format  (input_format),
    .chroma_order  (chroma_order),
    .pixel         (s_tdata),
    .luma          (luma),
    .chroma_first  (chroma_first),
    .chroma_second (chroma_second)
  );

  ryuv420_addr #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_addr (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .image_width  (image_width),
    .image_height (image_height),
    .luma_addr    (luma_addr),
    .chroma_addr  (chroma_addr),
    .chroma_valid (chroma_valid),
    .frame_end    (frame_end)
  );

  // chroma bytes read zero on odd columns
  assign chroma_mask = {BYTE_W{chroma_valid}};

  assign m_tdata = {{M_PAD_W{1'b0}}, chroma_addr, chroma_second & chroma_mask,
                    chroma_first & chroma_mask, luma_addr, luma};
  assign m_tuser = chroma_valid;
  assign m_tlast = frame_end;

endmodule

### hw/rtl/ryuv420_checker.sv
`include "rgb_to_yuv420_semiplanar_assert.svh"

module ryuv420_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_tvalid,
  input logic                              s_tready,
  input logic                              m_tvalid,
  input logic                              m_tready,
  input logic [ryuv420_pkg::M_TDATA_W-1:0] m_tdata,
  input logic                              m_tuser,
  input logic                              m_tlast
);
  import ryuv420_pkg::*;

  localparam int CHROMA_LO = BYTE_W + LUMA_AW;

  // the output register holds a stalled transaction
  `RYUV_ASSERT(a_hold_valid, m_tvalid && !m_tready |=> m_tvalid, "result dropped while stalled")
  `RYUV_ASSERT(a_hold_data, m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled result changed")
  // input only backs up once the output register is full
  `RYUV_ASSERT(a_ready_free, !s_tready |-> m_tvalid, "input stalled with empty output")
  // odd columns carry no chroma bytes or offset
  `RYUV_ASSERT(a_chroma_zero, m_tvalid && !m_tuser |-> m_tdata[M_TDATA_W-1:CHROMA_LO] == '0, "chroma fields set on odd column")
  `RYUV_ASSERT_ALWAYS(a_reset_empty, rst |=> !m_tvalid, "result present after reset")

endmodule

bind rgb_to_yuv420_semiplanar ryuv420_checker u_checker (.*);

### bench/tb.sv
`timescale 1ns / 100ps

module tb;
  import ryuv420_pkg::*;

  // frame size limits, kept equal to the instance parameters
  localparam int FRAME_MAX_W = 4096;
  localparam int FRAME_MAX_H = 4096;
  // generous bound for the whole run with random sender gaps and receiver stalls
  localparam int CYCLE_LIMIT = 200000;
  localparam int RAND_PHASES = 8;
  localparam int RAND_ITEMS  = 70;

  typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  // one expected output transaction
  typedef struct packed {
    logic [BYTE_W-1:0]    luma;
    logic [LUMA_AW-1:0]   luma_addr;
    logic                 chroma_valid;
    logic [BYTE_W-1:0]    chroma_first;
    logic [BYTE_W-1:0]    chroma_second;
    logic [CHROMA_AW-1:0] chroma_addr;
    logic                 frame_end;
  } yuv_result_t;

  // predicts the nv12 / nv21 writes of each pixel and checks them in order
  class yuv_result_board;
    bit               fmt_565;
    bit               order_nv21;
    logic [CFG_W-1:0] width_reg  = WIDTH_RESET;
    logic [CFG_W-1:0] height_reg = HEIGHT_RESET;
    int               col_pos;
    int               row_pos;
    yuv_result_t      pending[$];
    int               err_count;

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        REG_INPUT_FORMAT: fmt_565 = (val[0] == FMT_RGB565);
        REG_CHROMA_ORDER: order_nv21 = (val[0] == ORDER_NV21);
        REG_IMAGE_WIDTH:  width_reg = val;
        REG_IMAGE_HEIGHT: height_reg = val;
        default: ;
      endcase
    endfunction

    // drop 12 fraction bits, saturate to a byte
    function int to_byte(int acc);
      int v;
      if (acc < 0) return 0;
      v = acc >> 12;
      return (v > 255) ? 255 : v;
    endfunction

    function void note_pixel(logic [PIXEL_W-1:0] px);
      int r, g, b, w, h, cr, cb;
      yuv_result_t nxt;
      w = (width_reg == 0) ? 1 :
          ((int'(width_reg) > FRAME_MAX_W) ? FRAME_MAX_W : int'(width_reg));
      h = (height_reg == 0) ? 1 :
          ((int'(height_reg) > FRAME_MAX_H) ? FRAME_MAX_H : int'(height_reg));
      if (fmt_565) begin
        r = int'({px[15:11], px[15:13]});
        g = int'({px[10:5], px[10:9]});
        b = int'({px[4:0], px[4:2]});
      end else begin
        r = int'(px[7:0]);
        g = int'(px[15:8]);
        b = int'(px[23:16]);
      end
      nxt = '0;
      nxt.luma = BYTE_W'(to_byte(1225 * r + 2404 * g + 467 * b));
      nxt.luma_addr = LUMA_AW'(row_pos * w + col_pos);
      nxt.chroma_valid = (col_pos % 2 == 0);
      if (nxt.chroma_valid) begin
        cr = to_byte(524288 + 2048 * r - 1715 * g - 333 * b);
        cb = to_byte(524288 - 691 * r - 1357 * g + 2048 * b);
        nxt.chroma_first = BYTE_W'(order_nv21 ? cr : cb);
        nxt.chroma_second = BYTE_W'(order_nv21 ? cb : cr);
        nxt.chroma_addr = CHROMA_AW'(w * h + (row_pos >> 1) * w + col_pos);
      end
      // raster position, a counter past a shrunken size wraps here too
      if (col_pos + 1 >= w) begin
        col_pos = 0;
        if (row_pos + 1 >= h) begin
          row_pos = 0;
          nxt.frame_end = 1'b1;
        end else begin
          row_pos = row_pos + 1;
        end
      end else begin
        col_pos = col_pos + 1;
      end
      pending.push_back(nxt);
    endfunction

    function void check_yuv(logic [M_TDATA_W-1:0] data, logic user, logic last);
      yuv_result_t want;
      if (pending.size() == 0) begin
        $error("result with no pixel pending, tdata %h", data);
        err_count++;
        return;
      end
      want = pending.pop_front();
      if (data[7:0] !== want.luma) begin
        $error("luma expected %0d actual %0d", want.luma, data[7:0]);
        err_count++;
      end
      if (data[31:8] !== want.luma_addr) begin
        $error("luma_addr expected %0d actual %0d", want.luma_addr, data[31:8]);
        err_count++;
      end
      if (user !== want.chroma_valid) begin
        $error("chroma_valid expected %0d actual %0d", want.chroma_valid, user);
        err_count++;
      end
      if (data[39:32] !== want.chroma_first) begin
        $error("chroma_first expected %0d actual %0d", want.chroma_first, data[39:32]);
        err_count++;
      end
      if (data[47:40] !== want.chroma_second) begin
        $error("chroma_second expected %0d actual %0d", want.chroma_second, data[47:40]);
        err_count++;
      end
      if (data[72:48] !== want.chroma_addr) begin
        $error("chroma_addr expected %0d actual %0d", want.chroma_addr, data[72:48]);
        err_count++;
      end
      if (last !== want.frame_end) begin
        $error("frame_end expected %0d actual %0d", want.frame_end, last);
        err_count++;
      end
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [PIXEL_W-1:0]     s_tdata = '0;    // pixel[31:0]
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  // luma, luma_addr, chroma_first, chroma_second, chroma_addr, zero pad
  logic [M_TDATA_W-1:0]   m_tdata;
  logic                   m_tuser;         // chroma_valid
  logic                   m_tlast;         // frame_end
  logic                   cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_W-1:0]       cfg_data = '0;

  yuv_result_board board = new;
  idle_mode_t      idle_mode = IDLE_NONE;
  int              cycle_count = 0;

  rgb_to_yuv420_semiplanar #(
    .MAX_WIDTH  (FRAME_MAX_W),
    .MAX_HEIGHT (FRAME_MAX_H)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // watchdog: a hung handshake ends the run here
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // receiver: samples the transaction at the edge, then picks the next ready
  initial begin
    int stall_pct;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready)
        board.check_yuv(m_tdata, m_tuser, m_tlast);
      stall_pct = (idle_mode == IDLE_RECV) ? 79 : (idle_mode == IDLE_BOTH) ? 28 : 0;
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // one pixel transaction; valid stays high when the next pixel follows at once
  task automatic send_pixel(input logic [PIXEL_W-1:0] px);
    int gap_pct;
    gap_pct = (idle_mode == IDLE_SEND) ? 79 : (idle_mode == IDLE_BOTH) ? 28 : 0;
    while ($urandom_range(99) < gap_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= px;
    do @(posedge clk); while (!s_tready);
    board.note_pixel(px);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    board.set_reg(idx, val);
  endtask

  // register writes only once the pipeline has drained
  task automatic load_config(input logic fmt, input logic order,
                             input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
    s_tvalid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    put_reg(REG_INPUT_FORMAT, CFG_W'(fmt));
    put_reg(REG_CHROMA_ORDER, CFG_W'(order));
    put_reg(REG_IMAGE_WIDTH, w);
    put_reg(REG_IMAGE_HEIGHT, h);
    cfg_wr_en <= 1'b0;
  endtask

  // mostly tiny frames so wraps and frame ends are frequent, plus the extremes
  function automatic logic [CFG_W-1:0] pick_size();
    case ($urandom_range(9))
      0: return '0;
      1: return CFG_W'(1);
      2: return CFG_W'(2);
      3: return CFG_W'(FRAME_MAX_W);
      4: return 13'h1FFF;
      5: return CFG_W'($urandom_range(8191));
      default: return CFG_W'($urandom_range(9, 2));
    endcase
  endfunction

  initial begin
    logic [PIXEL_W-1:0] dir_8888[$];
    logic [PIXEL_W-1:0] dir_565[$];
    logic [PIXEL_W-1:0] dir_big[$];
    logic [PIXEL_W-1:0] dir_pair[$];

    // primaries, white, black and alpha only, at reset settings (8888, nv12)
    dir_8888 = '{32'h0000_00FF, 32'h0000_0000, 32'h0000_FF00,
                 32'hFF00_0000, 32'h00FF_0000, 32'hFFFF_FFFF,
                 32'h00FF_FFFF};
    // 565 corners, upper half word must be ignored
    dir_565 = '{32'h0000_FFFF, 32'h0000_F800, 32'h0000_07E0,
                32'h0000_001F, 32'hFFFF_0000, 32'h0000_0000};
    dir_big = '{32'h0000_00FF, 32'h00FF_0000, 32'h0000_0000,
                32'hFFFF_FFFF};
    dir_pair = '{32'h0000_FFFF, 32'h0000_0000, 32'h0000_8410,
                 32'h0000_7BEF};

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_8888[i]) send_pixel(dir_8888[i]);

    // zero sizes clamp to 1x1: every pixel ends a frame, nv21 order
    load_config(FMT_RGB565, ORDER_NV21, 13'd0, 13'd0);
    foreach (dir_565[i]) send_pixel(dir_565[i]);

    // oversized registers clamp to the maximum frame
    load_config(FMT_RGBA8888, ORDER_NV21, 13'h1FFF, 13'h1FFF);
    foreach (dir_big[i]) send_pixel(dir_big[i]);

    // shrink mid-row: the column already past the width wraps on the next pixel
    load_config(FMT_RGB565, ORDER_NV12, 13'd2, 13'd1);
    foreach (dir_pair[i]) send_pixel(dir_pair[i]);

    // random phases, each idle mode in turn, counters carried across
    for (int p = 0; p < RAND_PHASES; p++) begin
      load_config(1'($urandom_range(1)), 1'($urandom_range(1)), pick_size(), pick_size());
      idle_mode = idle_mode_t'(p % 4);
      for (int n = 0; n < RAND_ITEMS; n++)
        send_pixel($urandom());
    end

    s_tvalid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (board.err_count == 0 && board.pending.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
